### hw/rtl/kewr_pkg.sv
`default_nettype none
package kewr_pkg;

  localparam int KEY_W    = 8;
  localparam int STATUS_W = 3;
  localparam int WINID_W  = 3;

  // Control-T: 'T' - '@'
  localparam logic [KEY_W-1:0] SWITCH_KEY = 8'd20;

  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ACTIVE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SWITCHED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EVENT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd6;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [STATUS_W-1:0] status_t;

endpackage
`default_nettype wire

### hw/rtl/kewr_ram.sv
`default_nettype none
module kewr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/keyboard_event_window_router.sv
// Keyboard event window router: one key FIFO per grid window.
// Input channel (in_valid / in_stall): in_func 0 delivers a key. Key 20 steps the
// active window 0..WINDOWS-1, then to none (WINDOWS), then back to 0; any other
// key is queued in the active window's FIFO (QUEUE_DEPTH-2 entries) or dropped.
// in_func 1 reads up to in_max_count keys from window in_window_index.
// Result channel (out_valid / out_stall): one item per key arrival or failed
// read, one item per popped key on a read; out_last marks the final one.
// Timing: a single-result item is registered and shows in the cycle after
// acceptance; such items can be taken every cycle while the output is not
// stalled. A read that pops n keys passes each key through the key memory's
// read register and then the output register, one key per cycle when not stalled;
// the next item is taken once the last key is in the output register, and the
// memory read is kept one read ahead of the output. A stalled output register
// holds its item; the pop sequence and the input channel wait behind it.
// Reset clears the active window to none and empties every FIFO (pointers and
// counts only; the key memory is not cleared and needs no sweep).
`default_nettype none
module keyboard_event_window_router #(
  parameter int ROW_COUNT    = 2,
  parameter int COLUMN_COUNT = 2,
  parameter int QUEUE_DEPTH  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_func,
  input  wire logic [7:0] in_key_code,
  input  wire logic [7:0] in_window_index,
  input  wire logic [7:0] in_max_count,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic [7:0]      out_event_key,
  output logic [2:0]      out_active_window_now,
  output logic            out_last
);

  localparam int WINDOWS   = ROW_COUNT * COLUMN_COUNT;
  localparam int QUEUE_CAP = QUEUE_DEPTH - 2;
  localparam int WB        = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int NSLOT     = 2 ** WB;
  localparam int AWB       = $clog2(WINDOWS + 1);
  localparam int PB        = (QUEUE_CAP > 1) ? $clog2(QUEUE_CAP) : 1;
  localparam int CB        = $clog2(QUEUE_CAP + 1);
  localparam int MEM_AW    = WB + PB;
  localparam int MEM_DEPTH = 2 ** MEM_AW;

  localparam logic [AWB-1:0] NONE_WIN  = AWB'(WINDOWS);
  localparam logic [7:0]     WIN_LIMIT = 8'(WINDOWS);
  localparam logic [PB-1:0]  PTR_LAST  = PB'(QUEUE_CAP - 1);
  localparam logic [CB-1:0]  CNT_CAP   = CB'(QUEUE_CAP);
  localparam logic [CB-1:0]  CNT_ONE   = CB'(1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DATA = 1'b1;

  logic                    state_r, state_nxt;
  logic [AWB-1:0]          active_r, active_nxt;
  logic [PB-1:0]           rd_ptr_r [NSLOT];
  logic [PB-1:0]           rd_ptr_nxt [NSLOT];
  logic [PB-1:0]           wr_ptr_r [NSLOT];
  logic [PB-1:0]           wr_ptr_nxt [NSLOT];
  logic [CB-1:0]           cnt_r [NSLOT];
  logic [CB-1:0]           cnt_nxt [NSLOT];
  logic [WB-1:0]           pop_win_r, pop_win_nxt;
  logic [CB-1:0]           remain_r, remain_nxt;

  logic                    out_valid_r, out_valid_nxt;
  kewr_pkg::status_t       out_status_r, out_status_nxt;
  kewr_pkg::key_t          out_key_r, out_key_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [2:0]              out_win_r, out_win_nxt;

  logic                    in_accept;
  logic                    out_free;
  logic                    act_valid;
  logic                    win_ok;
  logic [WB-1:0]           idx;
  logic [PB-1:0]           sel_rp, sel_wp;
  logic [CB-1:0]           sel_cnt;
  logic [CB-1:0]           pop_n;
  logic                    mem_we, mem_re;
  kewr_pkg::key_t          mem_rdata;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign act_valid = active_r < NONE_WIN;
  assign win_ok    = in_window_index < WIN_LIMIT;

  always_comb begin
    if (state_r == S_DATA) begin
      idx = pop_win_r;
    end else if (in_func) begin
      idx = in_window_index[WB-1:0];
    end else begin
      idx = active_r[WB-1:0];
    end
  end

  assign sel_rp  = rd_ptr_r[idx];
  assign sel_wp  = wr_ptr_r[idx];
  assign sel_cnt = cnt_r[idx];
  assign pop_n   = (in_max_count < 8'(sel_cnt)) ? in_max_count[CB-1:0] : sel_cnt;

  // Writes happen only for a queued key, reads only for a read request or while
  // popping, so an entry is never read and written in the same cycle.
  kewr_ram #(
    .WIDTH(kewr_pkg::KEY_W),
    .DEPTH(MEM_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({idx, sel_wp}),
    .wdata (in_key_code),
    .re    (mem_re),
    .raddr ({idx, sel_rp}),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    cnt_nxt        = cnt_r;
    pop_win_nxt    = pop_win_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = '0;
          out_last_nxt  = 1'b1;
          if (!in_func) begin
            if (in_key_code == kewr_pkg::SWITCH_KEY) begin
              active_nxt     = act_valid ? active_r + AWB'(1) : '0;
              out_status_nxt = kewr_pkg::ST_SWITCHED;
            end else if (!act_valid) begin
              out_status_nxt = kewr_pkg::ST_NO_ACTIVE;
            end else if (sel_cnt >= CNT_CAP) begin
              out_status_nxt = kewr_pkg::ST_FULL;
            end else begin
              mem_we          = 1'b1;
              wr_ptr_nxt[idx] = (sel_wp == PTR_LAST) ? '0 : sel_wp + PB'(1);
              cnt_nxt[idx]    = sel_cnt + CNT_ONE;
              out_status_nxt  = kewr_pkg::ST_QUEUED;
            end
          end else if (!win_ok) begin
            out_status_nxt = kewr_pkg::ST_INVALID;
          end else if (pop_n == '0) begin
            out_status_nxt = kewr_pkg::ST_NONE;
          end else begin
            // first read goes out now; results start from S_DATA
            out_valid_nxt   = out_valid_r && out_stall;
            mem_re          = 1'b1;
            rd_ptr_nxt[idx] = (sel_rp == PTR_LAST) ? '0 : sel_rp + PB'(1);
            cnt_nxt[idx]    = sel_cnt - CNT_ONE;
            pop_win_nxt     = idx;
            remain_nxt      = pop_n;
            state_nxt       = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = kewr_pkg::ST_EVENT;
          out_key_nxt    = mem_rdata;
          out_last_nxt   = (remain_r == CNT_ONE);
          remain_nxt     = remain_r - CNT_ONE;
          if (remain_r == CNT_ONE) begin
            state_nxt = S_IDLE;
          end else begin
            // fetch the next key while this one moves to the output register
            mem_re          = 1'b1;
            rd_ptr_nxt[idx] = (sel_rp == PTR_LAST) ? '0 : sel_rp + PB'(1);
            cnt_nxt[idx]    = sel_cnt - CNT_ONE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_win_nxt = (out_valid_nxt && !(out_valid_r && out_stall)) ? 3'(active_nxt) : out_win_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= NONE_WIN;
      out_valid_r <= 1'b0;
      remain_r    <= '0;
      pop_win_r   <= '0;
      for (int i = 0; i < NSLOT; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        cnt_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      remain_r    <= remain_nxt;
      pop_win_r   <= pop_win_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_last_r   <= out_last_nxt;
    out_win_r    <= out_win_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_event_key         = out_key_r;
  assign out_active_window_now = out_win_r;
  assign out_last              = out_last_r;

endmodule
`default_nettype wire

### bench/keyboard_event_window_router_tb.sv
`timescale 1ns / 1ps
module keyboard_event_window_router_tb;

  localparam int ROWS      = 2;
  localparam int COLS      = 2;
  localparam int DEPTH     = 16;
  localparam int WINDOWS   = ROWS * COLS;
  localparam int CAP       = DEPTH - 2;
  localparam int N_RANDOM  = 460;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic            func;
    kewr_pkg::key_t  key;
    logic [7:0]      win;
    logic [7:0]      maxc;
  } key_item_t;

  typedef struct packed {
    kewr_pkg::status_t status;
    kewr_pkg::key_t    key;
    logic [2:0]        win_now;
    logic              is_last;
  } router_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_func = 1'b0;
  logic [7:0] in_key_code = '0;
  logic [7:0] in_window_index = '0;
  logic [7:0] in_max_count = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [2:0] out_status;
  logic [7:0] out_event_key;
  logic [2:0] out_active_window_now;
  logic out_last;

  keyboard_event_window_router #(
    .ROW_COUNT(ROWS),
    .COLUMN_COUNT(COLS),
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_key_code(in_key_code),
    .in_window_index(in_window_index),
    .in_max_count(in_max_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_event_key(out_event_key),
    .out_active_window_now(out_active_window_now),
    .out_last(out_last)
  );

  always #1 clk = ~clk;

  key_item_t      pending_keys[$];
  router_result_t expected_results[$];
  int error_count = 0;
  int items_total = 0;
  int items_taken = 0;

  // predictor state
  logic [2:0]      active_sel;
  kewr_pkg::key_t  window_store[WINDOWS][CAP];
  int              window_rd[WINDOWS];
  int              window_wr[WINDOWS];
  int              window_cnt[WINDOWS];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic clear_router_model();
    active_sel = 3'(WINDOWS);
    for (int w = 0; w < WINDOWS; w++) begin
      window_rd[w] = 0;
      window_wr[w] = 0;
      window_cnt[w] = 0;
    end
  endtask

  task automatic push_result(input kewr_pkg::status_t st, input kewr_pkg::key_t k,
                             input logic lst);
    router_result_t r;
    r.status = st;
    r.key = k;
    r.win_now = active_sel;
    r.is_last = lst;
    expected_results.push_back(r);
  endtask

  task automatic predict_router_outputs(input key_item_t it);
    int w;
    int n;
    if (!it.func) begin
      if (it.key == kewr_pkg::SWITCH_KEY) begin
        active_sel = (active_sel >= 3'(WINDOWS)) ? 3'd0 : active_sel + 3'd1;
        push_result(kewr_pkg::ST_SWITCHED, '0, 1'b1);
      end else if (active_sel >= 3'(WINDOWS)) begin
        push_result(kewr_pkg::ST_NO_ACTIVE, '0, 1'b1);
      end else begin
        w = int'(active_sel);
        if (window_cnt[w] >= CAP) begin
          push_result(kewr_pkg::ST_FULL, '0, 1'b1);
        end else begin
          window_store[w][window_wr[w]] = it.key;
          window_wr[w] = (window_wr[w] + 1) % CAP;
          window_cnt[w]++;
          push_result(kewr_pkg::ST_QUEUED, '0, 1'b1);
        end
      end
    end else if (it.win >= 8'(WINDOWS)) begin
      push_result(kewr_pkg::ST_INVALID, '0, 1'b1);
    end else begin
      w = int'(it.win);
      n = (window_cnt[w] > int'(it.maxc)) ? int'(it.maxc) : window_cnt[w];
      if (n == 0) begin
        push_result(kewr_pkg::ST_NONE, '0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++) begin
          push_result(kewr_pkg::ST_EVENT, window_store[w][window_rd[w]], (i == n - 1));
          window_rd[w] = (window_rd[w] + 1) % CAP;
          window_cnt[w]--;
        end
      end
    end
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic add_item(input logic f, input kewr_pkg::key_t k, input logic [7:0] w,
                          input logic [7:0] m);
    key_item_t it;
    it.func = f;
    it.key = k;
    it.win = w;
    it.maxc = m;
    pending_keys.push_back(it);
    items_total++;
  endtask

  task automatic add_key(input kewr_pkg::key_t k);
    add_item(1'b0, k, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic add_read(input logic [7:0] w, input logic [7:0] m);
    add_item(1'b1, 8'($urandom_range(0, 255)), w, m);
  endtask

  // driver
  int  in_gap = 0;
  bit  in_calm = 1'b0;
  key_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_router_model();
    end else begin
      if (in_valid && !in_stall) begin
        predict_router_outputs({in_func, in_key_code, in_window_index, in_max_count});
        items_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if ($urandom_range(0, 49) == 0) in_calm = ~in_calm;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_keys.size() > 0) begin
          next_item = pending_keys.pop_front();
          in_valid <= 1'b1;
          in_func <= next_item.func;
          in_key_code <= next_item.key;
          in_window_index <= next_item.win;
          in_max_count <= next_item.maxc;
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  out_hold = 0;
  bit  out_calm = 1'b0;
  router_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected item status=%0d key=%02h win=%0d last=%0b",
                                    out_status, out_event_key, out_active_window_now,
                                    out_last));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_event_key !== want.key)
            report_mismatch($sformatf("event_key got %02h want %02h", out_event_key,
                                      want.key));
          if (out_active_window_now !== want.win_now)
            report_mismatch($sformatf("active_window_now got %0d want %0d",
                                      out_active_window_now, want.win_now));
          if (out_last !== want.is_last)
            report_mismatch($sformatf("last got %0b want %0b", out_last, want.is_last));
        end
      end
      if ($urandom_range(0, 49) == 0) out_calm = ~out_calm;
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_hold = pick_gap(out_calm);
        out_stall <= (out_hold > 0);
        if (out_hold > 0) out_hold--;
      end
    end
  end

  // watchdog: cycles without any handshake
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("keyboard_event_window_router_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int burst;
    // no window active yet
    add_key(8'h41);
    add_key(kewr_pkg::SWITCH_KEY);
    // fill window 0, extremes of the key code included
    add_key(8'h00);
    add_key(8'hFF);
    for (int i = 0; i < CAP - 2; i++) add_key(8'($urandom_range(0, 255)) ^ 8'h80);
    add_key(8'h55);        // dropped, FIFO full
    add_read(8'd0, 8'd0);  // zero count
    add_read(8'd0, 8'd3);  // partial read
    add_read(8'd0, 8'hFF); // asks for more than queued
    add_read(8'd0, 8'd5);  // now empty
    add_read(8'(WINDOWS), 8'd1);
    add_read(8'hFF, 8'hFF);

    for (int i = 0; i < N_RANDOM; ) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        burst = $urandom_range(8, 18);
        for (int j = 0; j < burst; j++) add_key(8'($urandom_range(0, 255)));
        i += burst;
      end else if (r < 20) begin
        add_key(kewr_pkg::SWITCH_KEY);
        i++;
      end else if (r < 60) begin
        add_key(8'($urandom_range(0, 255)));
        i++;
      end else begin
        add_read(($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, WINDOWS))
                                             : 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, CAP + 2))
                                            : 8'($urandom_range(0, 255)));
        i++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < items_total || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("keyboard_event_window_router_tb: clean");
    end else begin
      $display("keyboard_event_window_router_tb: errors");
    end
    $finish;
  end

endmodule
